>>> hdl/glcm_four_direction_accumulator_defines.svh
`ifndef GLCM_FOUR_DIRECTION_ACCUMULATOR_DEFINES_SVH
`define GLCM_FOUR_DIRECTION_ACCUMULATOR_DEFINES_SVH
// Assertion helpers.
`define GLCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glcm check failed");
`define GLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glcm check failed");
`endif

>>> hdl/glcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package glcm_pkg;
    localparam int LEVELS     = 16;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int CNT_W      = 20;
    localparam int TAB_AW     = 2 + 2 * LVL_W;
    localparam int TAB_DEPTH  = 4 * LEVELS * LEVELS;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_QUANT  = 2'd2;
    localparam logic [1:0] CFG_MASK   = 2'd3;

    localparam logic [1:0] DIR_H   = 2'd0;
    localparam logic [1:0] DIR_V   = 2'd1;
    localparam logic [1:0] DIR_D45 = 2'd2;
    localparam logic [1:0] DIR_D135 = 2'd3;

    // classified command from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic             done;       // pixel that ends or follows the image end, or done flag for read
        logic [3:0]       bump;       // per-direction enable
        logic [LVL_W-1:0] q;
        logic [LVL_W-1:0] left;
        logic [LVL_W-1:0] above;
        logic [LVL_W-1:0] upleft;
        logic [LVL_W-1:0] upright;
        logic [1:0]       dir;
        logic [LVL_W-1:0] a;
        logic [LVL_W-1:0] b;
    } t_cmd;
endpackage
`default_nettype wire

>>> hdl/glcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module glcm_front
    import glcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_pixel,
    input  wire logic [1:0]  i_direction,
    input  wire logic [3:0]  i_first_level,
    input  wire logic [3:0]  i_second_level,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_full
);
    logic [10:0]      r_width, r_height;
    logic             r_quant;
    logic [3:0]       r_mask;
    logic [LVL_W-1:0] line_mem [MAX_WIDTH];
    logic [LVL_W-1:0] r_left, r_upleft;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    // stage 1: item held while line store reads
    logic             r_s1_valid;
    logic [1:0]       r_s1_op;
    logic [LVL_W-1:0] r_s1_q;
    logic [1:0]       r_s1_dir;
    logic [LVL_W-1:0] r_s1_a, r_s1_b;
    logic [LVL_W-1:0] r_rd_above, r_rd_right;
    logic [COL_W-1:0] rd_col;
    logic [COL_W:0]   col_p1;
    logic [10:0]      w_eff, h_eff;
    logic [LVL_W-1:0] q_in;
    logic [7:0]       q_raw;
    logic             accept, s1_fire, img_done, row_end;

    assign w_eff = (r_width == 11'd0) ? 11'd1
                 : (r_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height == 11'd0) ? 11'd1
                 : (r_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : r_height;
    assign q_raw = r_quant ? (i_pixel >> LVL_W) : i_pixel;
    assign q_in  = (q_raw > 8'(LEVELS - 1)) ? LVL_W'(LEVELS - 1) : q_raw[LVL_W-1:0];

    // stage 1 only moves one item at a time: pixel state is updated at s1 fire
    assign s1_fire = r_s1_valid && !i_cmd_full;
    assign o_stall = r_s1_valid;
    assign accept  = i_valid && !o_stall;
    assign img_done = (r_row >= h_eff);
    assign col_p1  = {1'b0, r_col} + 1'b1;
    assign row_end = ({1'b0, col_p1} >= {1'b0, w_eff});
    assign rd_col  = col_p1[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_above <= line_mem[r_col];
            r_rd_right <= line_mem[rd_col];
        end
        if (s1_fire && r_s1_op == OP_PIXEL && !img_done) begin
            line_mem[r_col] <= r_s1_q;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else begin
            n_col = col_p1[COL_W-1:0];
        end
    end

    always_comb begin
        o_cmd_valid   = s1_fire && r_s1_op != OP_RSVD;
        o_cmd         = '0;
        o_cmd.op      = r_s1_op;
        o_cmd.q       = r_s1_q;
        o_cmd.left    = r_left;
        o_cmd.above   = r_rd_above;
        o_cmd.upleft  = r_upleft;
        o_cmd.upright = r_rd_right;
        o_cmd.dir     = r_s1_dir;
        o_cmd.a       = r_s1_a;
        o_cmd.b       = r_s1_b;
        if (r_s1_op == OP_PIXEL) begin
            o_cmd.done = img_done;
            if (!img_done) begin
                o_cmd.bump[0] = r_mask[0] && r_col != '0;
                o_cmd.bump[1] = r_mask[1] && r_row != '0;
                o_cmd.bump[2] = r_mask[2] && r_row != '0 && r_col != '0;
                o_cmd.bump[3] = r_mask[3] && r_row != '0 && !row_end;
                o_cmd.done    = row_end && (n_row >= h_eff);
            end
        end else begin
            o_cmd.done = img_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 11'(MAX_WIDTH);
            r_height   <= 11'(MAX_HEIGHT);
            r_quant    <= 1'b1;
            r_mask     <= 4'hf;
            r_s1_valid <= 1'b0;
            r_left     <= '0;
            r_upleft   <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_QUANT:  r_quant  <= i_cfg_data[0];
                    CFG_MASK:   r_mask   <= i_cfg_data[3:0];
                    default:    r_width  <= r_width;
                endcase
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                if (r_s1_op == OP_PIXEL && !img_done) begin
                    r_left   <= r_s1_q;
                    r_upleft <= r_rd_above;
                    r_col    <= n_col;
                    r_row    <= n_row;
                end else if (r_s1_op == OP_CLEAR) begin
                    r_left   <= '0;
                    r_upleft <= '0;
                    r_col    <= '0;
                    r_row    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= i_op;
            r_s1_q   <= q_in;
            r_s1_dir <= i_direction;
            r_s1_a   <= i_first_level;
            r_s1_b   <= i_second_level;
        end
    end
endmodule
`default_nettype wire

>>> hdl/glcm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module glcm_queue
    import glcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_data,
    output logic      o_full,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_cmd      o_data
);
    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[Q_AW] != r_rp[Q_AW]) && (r_wp[Q_AW-1:0] == r_rp[Q_AW-1:0]);
    assign o_data  = r_mem[r_rp[Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[Q_AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/glcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module glcm_back
    import glcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [19:0]      o_count,
    output logic             o_image_done
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_SEL   = 3'd3;
    localparam logic [2:0] ST_RDOUT = 3'd4;
    localparam logic [2:0] ST_ZERO  = 3'd5;

    logic [CNT_W-1:0]  tab_mem [TAB_DEPTH];
    logic [2:0]        r_st;
    logic [1:0]        r_d;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_rdata;
    logic [TAB_AW-1:0] addr, r_addr, r_zaddr;
    logic [LVL_W-1:0]  first_l;
    logic              r_ovalid;
    logic              out_free, take, more, set_out;

    assign out_free = !r_ovalid || !i_stall;
    assign take     = (r_st == ST_IDLE) && !i_empty && out_free;
    assign o_pop    = take;
    assign o_valid  = r_ovalid;

    always_comb begin
        case (r_d)
            DIR_H:   more = |r_cmd.bump[3:1];
            DIR_V:   more = |r_cmd.bump[3:2];
            DIR_D45: more = r_cmd.bump[3];
            default: more = 1'b0;
        endcase
    end

    assign set_out = (take && i_cmd.op == OP_PIXEL && i_cmd.bump == 4'd0)
                   || (r_st == ST_WR && !more) || (r_st == ST_RDOUT);

    always_comb begin
        case (r_d)
            DIR_H:   first_l = r_cmd.left;
            DIR_V:   first_l = r_cmd.above;
            DIR_D45: first_l = r_cmd.upleft;
            default: first_l = r_cmd.upright;
        endcase
        addr = {r_d, first_l, r_cmd.q};
        if (r_st == ST_RDOUT || (take && i_cmd.op == OP_READ)) begin
            addr = take ? {i_cmd.dir, i_cmd.a, i_cmd.b} : r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= tab_mem[addr];
        r_addr  <= addr;
        if (r_st == ST_ZERO) begin
            tab_mem[r_zaddr] <= '0;
        end else if (r_st == ST_WR && r_rdata != {CNT_W{1'b1}}) begin
            tab_mem[r_addr] <= r_rdata + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_ZERO;
            r_zaddr  <= '0;
            r_ovalid <= 1'b0;
            r_d      <= '0;
        end else begin
            r_ovalid <= set_out || (r_ovalid && i_stall);
            case (r_st)
                ST_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        r_d   <= DIR_H;
                        if (i_cmd.op == OP_CLEAR) begin
                            r_st    <= ST_ZERO;
                            r_zaddr <= '0;
                        end else if (i_cmd.op == OP_READ) begin
                            r_st <= ST_RDOUT;
                        end else if (i_cmd.bump != 4'd0) begin
                            r_st <= ST_SEL;
                        end else begin
                            o_count      <= '0;
                            o_image_done <= i_cmd.done;
                        end
                    end
                end
                ST_SEL: begin
                    // find next enabled direction
                    if (r_cmd.bump[r_d]) begin
                        r_st <= ST_RD;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                ST_RD: begin
                    r_st <= ST_WR;
                end
                ST_WR: begin
                    if (more) begin
                        r_d  <= r_d + 1'b1;
                        r_st <= ST_SEL;
                    end else begin
                        r_st         <= ST_IDLE;
                        o_count      <= '0;
                        o_image_done <= r_cmd.done;
                    end
                end
                ST_RDOUT: begin
                    r_st         <= ST_IDLE;
                    o_count      <= r_rdata;
                    o_image_done <= r_cmd.done;
                end
                ST_ZERO: begin
                    r_zaddr <= r_zaddr + 1'b1;
                    if (r_zaddr == {TAB_AW{1'b1}}) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/glcm_four_direction_accumulator.sv
// Four-direction gray-level co-occurrence accumulator.
// Input channel (i_valid / o_stall): one beat carries op, pixel, direction,
// first_level and second_level. Op pixel quantizes the pixel to 16 levels,
// bumps up to four 16x16 tables and returns one result with count 0 and
// image_done. Op read returns one result with the selected count. Op clear
// zeroes all tables and the image position and returns nothing.
// Output channel (o_valid / i_stall): count and image_done.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 width, 1 height,
// 2 quantize enable, 3 direction mask; write only while idle.
// A front stage reads the line store (it holds one beat at a time and
// takes no new beat until that one has left) and feeds a 4-entry command
// queue; the back end owns the count table. Back end: a pixel with no
// table to bump returns its result with no table step, else each bumped
// direction goes through select, read and write steps and each skipped
// direction below the last bumped one through a select step; a read does
// a table read, then returns the count; a clear zeroes all table entries.
// Reset restores position and config defaults and zeroes the tables in
// one pass; the line store is not cleared. A stalled output holds, the
// queue fills, and o_stall then stays high.
`timescale 1ns / 1ps
`default_nettype none
module glcm_four_direction_accumulator
    import glcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_pixel,
    input  wire logic [1:0]  i_direction,
    input  wire logic [3:0]  i_first_level,
    input  wire logic [3:0]  i_second_level,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [19:0]      o_count,
    output logic             o_image_done
);
    t_cmd cmd_in, cmd_out;
    logic cmd_push, q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    glcm_front u_front (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_stall,
        .i_op, .i_pixel, .i_direction, .i_first_level, .i_second_level,
        .o_cmd_valid(cmd_push), .o_cmd(cmd_in), .i_cmd_full(q_full)
    );

    glcm_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(cmd_push), .i_data(cmd_in), .o_full(q_full), .o_empty(q_empty),
        .i_pop(q_pop), .o_data(cmd_out)
    );

    glcm_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(q_empty), .i_cmd(cmd_out), .o_pop(q_pop),
        .o_valid, .i_stall, .o_count, .o_image_done
    );
endmodule
`default_nettype wire

>>> hdl/glcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "glcm_four_direction_accumulator_defines.svh"
module glcm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [19:0] o_count,
    input wire logic        o_image_done
);
    `GLCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_count))
    `GLCM_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_image_done))
    `GLCM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind glcm_four_direction_accumulator glcm_checker u_glcm_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_count, .o_image_done
);
`default_nettype wire

>>> sim/tb_glcm_four_direction_accumulator.sv
`timescale 1ns / 1ps
module tb_glcm_four_direction_accumulator;
    import glcm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] op;
        logic [7:0] pixel;
        logic [1:0] direction;
        logic [3:0] first_level;
        logic [3:0] second_level;
    } t_beat;

    typedef struct {
        logic [19:0] count;
        logic        image_done;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_pixel = '0;
    logic [1:0]  i_direction = '0;
    logic [3:0]  i_first_level = '0;
    logic [3:0]  i_second_level = '0;
    logic        i_stall = 1'b1;
    logic        o_cfg_ready;
    logic        o_stall;
    logic        o_valid;
    logic [19:0] o_count;
    logic        o_image_done;

    glcm_four_direction_accumulator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_pixel        (i_pixel),
        .i_direction    (i_direction),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_count        (o_count),
        .o_image_done   (o_image_done)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block
    logic [10:0] sh_width = 11'd1024;
    logic [10:0] sh_height = 11'd1024;
    logic        sh_quant = 1'b1;
    logic [3:0]  sh_mask = 4'hF;
    logic [3:0]  sh_line [0:1023];
    logic [3:0]  sh_left = '0;
    logic [3:0]  sh_upleft = '0;
    int unsigned sh_col = 0;
    int unsigned sh_row = 0;
    logic [19:0] sh_tab [4][16][16];

    t_beat   pending_beats[$];
    t_result expected_results[$];
    int      errors = 0;
    int      results_seen = 0;
    bit      hold_done = 1'b0;

    task automatic clear_tables();
        for (int d = 0; d < 4; d++)
            for (int a = 0; a < 16; a++)
                for (int b = 0; b < 16; b++)
                    sh_tab[d][a][b] = '0;
        sh_left = '0;
        sh_upleft = '0;
        sh_col = 0;
        sh_row = 0;
    endtask

    task automatic bump_pair(input logic [1:0] dir, input logic [3:0] a, input logic [3:0] b);
        if (sh_mask[dir] && sh_tab[dir][a][b] != 20'hFFFFF)
            sh_tab[dir][a][b] = sh_tab[dir][a][b] + 20'd1;
    endtask

    task automatic predict_beat(input t_beat bt);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        logic [3:0]   q;
        logic [3:0]   above;
        t_result      r;
        w = (sh_width < 1) ? 1 : ((sh_width > 1024) ? 1024 : sh_width);
        h = (sh_height < 1) ? 1 : ((sh_height > 1024) ? 1024 : sh_height);
        case (bt.op)
            OP_PIXEL: begin
                if (sh_row >= h) begin
                    r.count = '0;
                    r.image_done = 1'b1;
                end else begin
                    if (sh_quant)
                        q = bt.pixel[7:4];
                    else
                        q = (bt.pixel > 8'd15) ? 4'd15 : bt.pixel[3:0];
                    c = sh_col;
                    above = sh_line[c];
                    if (sh_row >= 1) begin
                        bump_pair(DIR_V, above, q);
                        if (c >= 1) bump_pair(DIR_D45, sh_upleft, q);
                        if (c + 1 < w && c + 1 < 1024) bump_pair(DIR_D135, sh_line[c+1], q);
                    end
                    if (c >= 1) bump_pair(DIR_H, sh_left, q);
                    sh_upleft = above;
                    sh_line[c] = q;
                    sh_left = q;
                    c++;
                    if (c >= w) begin
                        c = 0;
                        sh_row++;
                    end
                    sh_col = c;
                    r.count = '0;
                    r.image_done = (sh_row >= h);
                end
                expected_results = {expected_results, r};
            end
            OP_READ: begin
                r.count = sh_tab[bt.direction][bt.first_level][bt.second_level];
                r.image_done = (sh_row >= h);
                expected_results = {expected_results, r};
            end
            OP_CLEAR: clear_tables();
            default: ;
        endcase
    endtask

    // driver
    int   send_gap = 0;
    int   send_cnt = 0;
    bit   send_burst = 1'b0;
    always @(posedge i_clk) begin
        t_beat bt;
        t_beat cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cur.op = i_op;
                cur.pixel = i_pixel;
                cur.direction = i_direction;
                cur.first_level = i_first_level;
                cur.second_level = i_second_level;
                predict_beat(cur);
            end
            if (i_valid && o_stall) begin
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_beats.size() > 0) begin
                bt = pending_beats.pop_front();
                i_valid <= 1'b1;
                i_op <= bt.op;
                i_pixel <= bt.pixel;
                i_direction <= bt.direction;
                i_first_level <= bt.first_level;
                i_second_level <= bt.second_level;
                send_cnt <= send_cnt + 1;
                if (send_cnt % 64 == 0) send_burst <= ($urandom_range(0, 2) == 0);
                send_gap <= send_burst ? 0 : $urandom_range(0, 8);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_wait = 0;
    int hold_cnt = 0;
    bit recv_burst = 1'b0;
    always @(posedge i_clk) begin
        t_result e;
        int w;
        int hl;
        w = recv_wait;
        hl = hold_cnt;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result count=%0d image_done=%0d", o_count, o_image_done);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_count !== e.count) begin
                    $error("count expected %0d actual %0d", e.count, o_count);
                    errors++;
                end
                if (o_image_done !== e.image_done) begin
                    $error("image_done expected %0d actual %0d", e.image_done, o_image_done);
                    errors++;
                end
            end
            results_seen++;
            if (results_seen % 50 == 0) recv_burst = ($urandom_range(0, 2) == 0);
            w = recv_burst ? 0 : $urandom_range(0, 8);
            if (results_seen == 60 && !hold_done) begin
                hl = HOLD_CYCLES;
                hold_done = 1'b1;
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else if (hl > 0) begin
            i_stall <= 1'b1;
            hl--;
        end else if (w > 0) begin
            i_stall <= 1'b1;
            w--;
        end else begin
            i_stall <= 1'b0;
        end
        recv_wait = w;
        hold_cnt = hl;
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_beat make_beat(logic [1:0] op, logic [7:0] pix, logic [1:0] dir,
                                        logic [3:0] a, logic [3:0] b);
        t_beat bt;
        bt.op = op;
        bt.pixel = pix;
        bt.direction = dir;
        bt.first_level = a;
        bt.second_level = b;
        return bt;
    endfunction

    task automatic queue_beat(input t_beat bt);
        pending_beats = {pending_beats, bt};
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 20));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_beat rand_read();
        return make_beat(OP_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:  sh_width = data;
            CFG_HEIGHT: sh_height = data;
            CFG_QUANT:  sh_quant = data[0];
            default:    sh_mask = data[3:0];
        endcase
    endtask

    task automatic run_image(input logic [10:0] w, input logic [10:0] h, input logic q,
                             input logic [3:0] m, input int npix);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_QUANT, {10'd0, q});
        write_reg(CFG_MASK, {7'd0, m});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_beat(make_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 2'd0, 4'd0, 4'd0));
        for (int i = 0; i < npix; i++) begin
            queue_beat(make_beat(OP_PIXEL, rand_pixel(), 2'($urandom_range(0, 3)),
                                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
            if ($urandom_range(0, 5) == 0) queue_beat(rand_read());
            if ($urandom_range(0, 40) == 0)
                queue_beat(make_beat(OP_UNUSED, rand_pixel(), 2'd0, 4'd0, 4'd0));
        end
        for (int i = 0; i < 6; i++) queue_beat(rand_read());
    endtask

    initial begin
        int w;
        int h;
        for (int i = 0; i < 1024; i++) sh_line[i] = '0;
        clear_tables();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, first row only
        queue_beat(make_beat(OP_PIXEL, 8'd0, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_PIXEL, 8'd255, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_PIXEL, 8'd255, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_PIXEL, 8'd16, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_PIXEL, 8'd15, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_READ, 8'd0, DIR_H, 4'd0, 4'd15));
        queue_beat(make_beat(OP_READ, 8'd0, DIR_H, 4'd15, 4'd15));
        queue_beat(make_beat(OP_READ, 8'd0, DIR_H, 4'd1, 4'd0));
        queue_beat(make_beat(OP_READ, 8'd0, DIR_V, 4'd15, 4'd0));
        queue_beat(make_beat(OP_UNUSED, 8'd255, 2'd3, 4'd15, 4'd15));
        queue_beat(make_beat(OP_CLEAR, 8'd0, 2'd0, 4'd0, 4'd0));
        queue_beat(make_beat(OP_READ, 8'd0, DIR_H, 4'd15, 4'd15));

        run_image(11'd3, 11'd2, 1'b0, 4'hF, 9);
        run_image(11'd0, 11'd2047, 1'b1, 4'hF, 20);
        run_image(11'd2, 11'd2, 1'b0, 4'h0, 6);
        run_image(11'd1024, 11'd2, 1'b1, 4'hF, 1030);
        for (int p = 0; p < 4; p++) begin
            w = $urandom_range(2, 10);
            h = $urandom_range(2, 6);
            run_image(11'(w), 11'(h), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      w * h + int'($urandom_range(0, 4)));
        end
        run_image(11'd4, 11'd3, 1'b1, 4'hF, 14);

        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
